// ===== src/kchd_pkg.sv =====
package kchd_pkg;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SETUP   = 3'd1,
    EV_NUMBER  = 3'd2,
    EV_CLEAR   = 3'd3,
    EV_SUBMIT  = 3'd4,
    EV_RESET   = 3'd5,
    EV_PAIRING = 3'd6,
    EV_OWNER   = 3'd7
  } event_e;

  typedef enum logic [1:0] {
    CFG_RESET_HOLD   = 2'd0,
    CFG_PAIRING_HOLD = 2'd1,
    CFG_OWNER_HOLD   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_KEY   = 1'b0,
    ACT_COMBO = 1'b1
  } action_e;

  localparam logic [1:0] KEY_PRESSED  = 2'd0;
  localparam logic [1:0] KEY_RELEASED = 2'd1;

  localparam logic [7:0] KEY_0    = 8'h30;  // '0'
  localparam logic [7:0] KEY_9    = 8'h39;  // '9'
  localparam logic [7:0] KEY_STAR = 8'h2A;  // '*'
  localparam logic [7:0] KEY_HASH = 8'h23;  // '#'

  localparam int unsigned ThrW  = 16;
  localparam int unsigned TimeW = 32;

  localparam logic [ThrW-1:0] RESET_HOLD_DEFAULT   = 16'd3000;
  localparam logic [ThrW-1:0] PAIRING_HOLD_DEFAULT = 16'd3000;
  localparam logic [ThrW-1:0] OWNER_HOLD_DEFAULT   = 16'd10000;

  typedef struct packed {
    logic             action;
    logic [7:0]       key_code;
    logic [1:0]       key_state;
    logic [TimeW-1:0] now_ms;
    logic             setup_mode;
    logic             reset_allowed;
    logic             owner_reset_allowed;
    logic             pairing_allowed;
  } in_item_t;

  typedef struct packed {
    event_e     event_code;
    logic [7:0] event_key;
  } out_item_t;

  typedef struct packed {
    logic [ThrW-1:0] reset_hold;
    logic [ThrW-1:0] pairing_hold;
    logic [ThrW-1:0] owner_hold;
  } thr_t;

  typedef struct packed {
    logic             star_held;
    logic             hash_held;
    logic             actions_suppressed;
    logic             reset_timing;
    logic [TimeW-1:0] reset_start;
    logic             pairing_timing;
    logic [TimeW-1:0] pairing_start;
    logic             owner_timing;
    logic [TimeW-1:0] owner_start;
  } combo_state_t;

endpackage

// ===== src/keypad_combo_hold_detector.sv =====
// Keypad combo hold detector. Key events and combo check ticks enter on the
// in_item channel; each accepted item yields exactly one result on the
// out_item channel (event_code none when nothing happens). Throughput is one
// item per clock while out_stall_i is low; an item passes the input register,
// then the result register, before its result can transfer. The whole decode
// and the three 32-bit wrapping elapsed-time compares sit in one combinational
// pass between those two registers, which is what sets the one-item-per-cycle
// figure. Hold thresholds are written through the cfg port (always ready) and
// must only change while no item is in flight.
module keypad_combo_hold_detector #(
  parameter logic [kchd_pkg::ThrW-1:0] ResetHoldInit   = kchd_pkg::RESET_HOLD_DEFAULT,
  parameter logic [kchd_pkg::ThrW-1:0] PairingHoldInit = kchd_pkg::PAIRING_HOLD_DEFAULT,
  parameter logic [kchd_pkg::ThrW-1:0] OwnerHoldInit   = kchd_pkg::OWNER_HOLD_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kchd_pkg::in_item_t  in_item_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kchd_pkg::out_item_t out_item_o,
  // threshold writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  kchd_pkg::thr_t         thr;
  kchd_pkg::combo_state_t st_q, st_d;
  kchd_pkg::combo_state_t core_st;
  kchd_pkg::out_item_t    core_res;
  kchd_pkg::in_item_t     in_item_q;
  kchd_pkg::out_item_t    out_item_q;
  logic                   in_valid_q, out_valid_q;
  logic                   advance, in_load, in_fire;

  kchd_cfg_regs #(
    .ResetHoldInit   (ResetHoldInit),
    .PairingHoldInit (PairingHoldInit),
    .OwnerHoldInit   (OwnerHoldInit)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .thr_o       (thr)
  );

  kchd_core u_core (
    .item_i (in_item_q),
    .st_i   (st_q),
    .thr_i  (thr),
    .st_o   (core_st),
    .res_o  (core_res)
  );

  // Result register frees up when empty or when its transfer completes.
  assign advance    = !out_valid_q || !out_stall_i;
  // The item in the input register is processed (and state committed) on advance.
  assign in_fire    = in_valid_q && advance;
  // Input register takes a new item when empty or when its item moves on.
  assign in_load    = !in_valid_q || advance;
  assign in_stall_o = !in_load;

  assign st_d = in_fire ? core_st : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_load) in_valid_q  <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
      st_q <= st_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) in_item_q  <= in_item_i;
    if (in_fire)               out_item_q <= core_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A fired hold always leaves actions suppressed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (core_res.event_code == kchd_pkg::EV_RESET ||
                core_res.event_code == kchd_pkg::EV_OWNER ||
                core_res.event_code == kchd_pkg::EV_PAIRING)
    |=> st_q.actions_suppressed)
    else $error("hold fired without suppression");

  // Only setup and number events carry a key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !(out_item_q.event_code == kchd_pkg::EV_SETUP ||
                     out_item_q.event_code == kchd_pkg::EV_NUMBER)
    |-> out_item_q.event_key == 8'd0)
    else $error("event key set on keyless event");

  // Backpressure only when both stages are full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // State never moves without an item being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(st_q))
    else $error("state changed without an item");

endmodule

// ===== src/kchd_cfg_regs.sv =====
module kchd_cfg_regs #(
  parameter logic [kchd_pkg::ThrW-1:0] ResetHoldInit   = kchd_pkg::RESET_HOLD_DEFAULT,
  parameter logic [kchd_pkg::ThrW-1:0] PairingHoldInit = kchd_pkg::PAIRING_HOLD_DEFAULT,
  parameter logic [kchd_pkg::ThrW-1:0] OwnerHoldInit   = kchd_pkg::OWNER_HOLD_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output kchd_pkg::thr_t      thr_o
);

  kchd_pkg::thr_t thr_q, thr_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    thr_d = thr_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        kchd_pkg::CFG_RESET_HOLD:   thr_d.reset_hold   = cfg_data_i;
        kchd_pkg::CFG_PAIRING_HOLD: thr_d.pairing_hold = cfg_data_i;
        kchd_pkg::CFG_OWNER_HOLD:   thr_d.owner_hold   = cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.reset_hold   <= ResetHoldInit;
      thr_q.pairing_hold <= PairingHoldInit;
      thr_q.owner_hold   <= OwnerHoldInit;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

// ===== src/kchd_core.sv =====
module kchd_core (
  input  kchd_pkg::in_item_t     item_i,
  input  kchd_pkg::combo_state_t st_i,
  input  kchd_pkg::thr_t         thr_i,
  output kchd_pkg::combo_state_t st_o,
  output kchd_pkg::out_item_t    res_o
);

  logic [kchd_pkg::TimeW-1:0] rst_start, own_start, pair_start;
  logic [kchd_pkg::TimeW-1:0] rst_el, own_el, pair_el;
  logic                       rst_hit, own_hit, pair_hit;

  // wrapping elapsed time for each hold; start snaps to now when not timing
  assign rst_start  = st_i.reset_timing   ? st_i.reset_start   : item_i.now_ms;
  assign own_start  = st_i.owner_timing   ? st_i.owner_start   : item_i.now_ms;
  assign pair_start = st_i.pairing_timing ? st_i.pairing_start : item_i.now_ms;
  assign rst_el     = item_i.now_ms - rst_start;
  assign own_el     = item_i.now_ms - own_start;
  assign pair_el    = item_i.now_ms - pair_start;
  assign rst_hit    = rst_el  >= {16'd0, thr_i.reset_hold};
  assign own_hit    = own_el  >= {16'd0, thr_i.owner_hold};
  assign pair_hit   = pair_el >= {16'd0, thr_i.pairing_hold};

  always_comb begin
    st_o  = st_i;
    res_o = '{event_code: kchd_pkg::EV_NONE, event_key: 8'd0};

    if (item_i.action == kchd_pkg::ACT_KEY) begin
      if (item_i.setup_mode) begin
        if (item_i.key_state == kchd_pkg::KEY_PRESSED) begin
          res_o = '{event_code: kchd_pkg::EV_SETUP, event_key: item_i.key_code};
        end
      end else if (item_i.key_code inside {[kchd_pkg::KEY_0:kchd_pkg::KEY_9]}) begin
        if (item_i.key_state == kchd_pkg::KEY_PRESSED) begin
          res_o = '{event_code: kchd_pkg::EV_NUMBER, event_key: item_i.key_code};
        end
      end else if (item_i.key_code == kchd_pkg::KEY_STAR) begin
        if (item_i.key_state == kchd_pkg::KEY_PRESSED) begin
          st_o.star_held = 1'b1;
        end else if (item_i.key_state == kchd_pkg::KEY_RELEASED) begin
          st_o.star_held = 1'b0;
          if (!st_i.actions_suppressed) res_o.event_code = kchd_pkg::EV_CLEAR;
        end
      end else if (item_i.key_code == kchd_pkg::KEY_HASH) begin
        if (item_i.key_state == kchd_pkg::KEY_PRESSED) begin
          st_o.hash_held = 1'b1;
        end else if (item_i.key_state == kchd_pkg::KEY_RELEASED) begin
          st_o.hash_held = 1'b0;
          if (!st_i.actions_suppressed) res_o.event_code = kchd_pkg::EV_SUBMIT;
        end
      end
    end else if (item_i.setup_mode) begin
      // combo check ignored in setup mode
    end else if (st_i.actions_suppressed && (st_i.star_held || st_i.hash_held)) begin
      // wait for both keys up after a fired hold
    end else if (st_i.star_held && st_i.hash_held) begin
      if (item_i.reset_allowed) begin
        if (rst_hit) begin
          st_o.actions_suppressed = 1'b1;
          st_o.reset_timing       = 1'b0;
          st_o.reset_start        = '0;
          res_o.event_code        = kchd_pkg::EV_RESET;
        end else begin
          st_o.reset_timing = 1'b1;
          st_o.reset_start  = rst_start;
        end
      end else begin
        st_o.reset_timing = 1'b0;
        st_o.reset_start  = '0;
        if (item_i.owner_reset_allowed) begin
          st_o.pairing_timing = 1'b0;
          st_o.pairing_start  = '0;
          if (own_hit) begin
            st_o.actions_suppressed = 1'b1;
            st_o.owner_timing       = 1'b0;
            st_o.owner_start        = '0;
            res_o.event_code        = kchd_pkg::EV_OWNER;
          end else begin
            st_o.owner_timing = 1'b1;
            st_o.owner_start  = own_start;
          end
        end else begin
          st_o.owner_timing = 1'b0;
          st_o.owner_start  = '0;
          if (!item_i.pairing_allowed) begin
            st_o.pairing_timing = 1'b0;
            st_o.pairing_start  = '0;
          end else if (pair_hit) begin
            st_o.actions_suppressed = 1'b1;
            st_o.pairing_timing     = 1'b0;
            st_o.pairing_start      = '0;
            res_o.event_code        = kchd_pkg::EV_PAIRING;
          end else begin
            st_o.pairing_timing = 1'b1;
            st_o.pairing_start  = pair_start;
          end
        end
      end
    end else begin
      // combo not held: drop all timers; suppression ends once both keys are up
      st_o.reset_timing       = 1'b0;
      st_o.reset_start        = '0;
      st_o.pairing_timing     = 1'b0;
      st_o.pairing_start      = '0;
      st_o.owner_timing       = 1'b0;
      st_o.owner_start        = '0;
      st_o.actions_suppressed = 1'b0;
    end
  end

endmodule

// ===== verif/keypad_event_checker.sv =====
module keypad_event_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  kchd_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  kchd_pkg::out_item_t out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output int                  mismatches_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // thresholds as the block should hold them
  logic [kchd_pkg::ThrW-1:0]  thr_reset, thr_pairing, thr_owner;

  // combo tracking state
  logic                       star_down, hash_down, muted;
  logic                       reset_run, pairing_run, owner_run;
  logic [kchd_pkg::TimeW-1:0] reset_t0, pairing_t0, owner_t0;

  kchd_pkg::out_item_t        expected_events[$];

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  function automatic kchd_pkg::out_item_t predict_event(input kchd_pkg::in_item_t it);
    kchd_pkg::out_item_t        r;
    logic [kchd_pkg::TimeW-1:0] elapsed;
    r.event_code = kchd_pkg::EV_NONE;
    r.event_key  = '0;
    if (it.action == kchd_pkg::ACT_KEY) begin
      if (it.setup_mode) begin
        if (it.key_state == kchd_pkg::KEY_PRESSED) begin
          r.event_code = kchd_pkg::EV_SETUP;
          r.event_key  = it.key_code;
        end
      end else if (it.key_code >= kchd_pkg::KEY_0 && it.key_code <= kchd_pkg::KEY_9) begin
        if (it.key_state == kchd_pkg::KEY_PRESSED) begin
          r.event_code = kchd_pkg::EV_NUMBER;
          r.event_key  = it.key_code;
        end
      end else if (it.key_code == kchd_pkg::KEY_STAR) begin
        if (it.key_state == kchd_pkg::KEY_PRESSED) begin
          star_down = 1'b1;
        end else if (it.key_state == kchd_pkg::KEY_RELEASED) begin
          star_down = 1'b0;
          if (!muted) r.event_code = kchd_pkg::EV_CLEAR;
        end
      end else if (it.key_code == kchd_pkg::KEY_HASH) begin
        if (it.key_state == kchd_pkg::KEY_PRESSED) begin
          hash_down = 1'b1;
        end else if (it.key_state == kchd_pkg::KEY_RELEASED) begin
          hash_down = 1'b0;
          if (!muted) r.event_code = kchd_pkg::EV_SUBMIT;
        end
      end
    end else if (!it.setup_mode && !(muted && (star_down || hash_down))) begin
      if (star_down && hash_down) begin
        if (it.reset_allowed) begin
          if (!reset_run) begin
            reset_run = 1'b1;
            reset_t0  = it.now_ms;
          end
          elapsed = it.now_ms - reset_t0;
          if (elapsed >= kchd_pkg::TimeW'(thr_reset)) begin
            muted        = 1'b1;
            reset_run    = 1'b0;
            reset_t0     = '0;
            r.event_code = kchd_pkg::EV_RESET;
          end
        end else begin
          reset_run = 1'b0;
          reset_t0  = '0;
          if (it.owner_reset_allowed) begin
            pairing_run = 1'b0;
            pairing_t0  = '0;
            if (!owner_run) begin
              owner_run = 1'b1;
              owner_t0  = it.now_ms;
            end
            elapsed = it.now_ms - owner_t0;
            if (elapsed >= kchd_pkg::TimeW'(thr_owner)) begin
              muted        = 1'b1;
              owner_run    = 1'b0;
              owner_t0     = '0;
              r.event_code = kchd_pkg::EV_OWNER;
            end
          end else begin
            owner_run = 1'b0;
            owner_t0  = '0;
            if (!it.pairing_allowed) begin
              pairing_run = 1'b0;
              pairing_t0  = '0;
            end else begin
              if (!pairing_run) begin
                pairing_run = 1'b1;
                pairing_t0  = it.now_ms;
              end
              elapsed = it.now_ms - pairing_t0;
              if (elapsed >= kchd_pkg::TimeW'(thr_pairing)) begin
                muted        = 1'b1;
                pairing_run  = 1'b0;
                pairing_t0   = '0;
                r.event_code = kchd_pkg::EV_PAIRING;
              end
            end
          end
        end
      end else begin
        reset_run   = 1'b0;
        reset_t0    = '0;
        pairing_run = 1'b0;
        pairing_t0  = '0;
        owner_run   = 1'b0;
        owner_t0    = '0;
        if (muted && !star_down && !hash_down) muted = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    kchd_pkg::out_item_t want;
    if (!rst_ni) begin
      thr_reset    = kchd_pkg::RESET_HOLD_DEFAULT;
      thr_pairing  = kchd_pkg::PAIRING_HOLD_DEFAULT;
      thr_owner    = kchd_pkg::OWNER_HOLD_DEFAULT;
      star_down    = 1'b0;
      hash_down    = 1'b0;
      muted        = 1'b0;
      reset_run    = 1'b0;
      pairing_run  = 1'b0;
      owner_run    = 1'b0;
      reset_t0     = '0;
      pairing_t0   = '0;
      owner_t0     = '0;
      expected_events.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          kchd_pkg::CFG_RESET_HOLD:   thr_reset   = cfg_data_i;
          kchd_pkg::CFG_PAIRING_HOLD: thr_pairing = cfg_data_i;
          kchd_pkg::CFG_OWNER_HOLD:   thr_owner   = cfg_data_i;
          default: ;  // unmapped index, dropped
        endcase
      end
      // results leave only after their item has passed both registers, so compare first
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result code %0d key %0h",
                                    out_item_i.event_code, out_item_i.event_key));
        end else begin
          want = expected_events.pop_front();
          if (out_item_i.event_code !== want.event_code)
            report_mismatch($sformatf("event_code %0d, expected %0d",
                                      out_item_i.event_code, want.event_code));
          if (out_item_i.event_key !== want.event_key)
            report_mismatch($sformatf("event_key %0h, expected %0h",
                                      out_item_i.event_key, want.event_key));
        end
      end
      if (in_valid_i && !in_stall_i) expected_events.push_back(predict_event(in_item_i));
      pending_o = expected_events.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int          PHASES         = 5;
  localparam int          PHASE_ITEMS    = 245;
  localparam int          HOLD_OFF_LEN   = 300;   // long output hold-off, in cycles
  localparam int          SETTLE_CYCLES  = 8;     // settle margin after the last result
  localparam int          STUCK_LIMIT    = 3000;  // cycles with no transfer at all
  localparam logic [1:0]  CFG_SPARE_IDX  = 2'd3;  // not mapped to any threshold

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  kchd_pkg::in_item_t  in_item     = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  kchd_pkg::out_item_t out_item;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index   = '0;
  logic [15:0]         cfg_data    = '0;

  int          mismatches;
  int          pending;

  // stimulus bookkeeping
  int          items_sent   = 0;
  int          burst_left   = 0;
  int          idle_cycles  = 0;
  bit          hold_off_req = 1'b0;
  logic [31:0] hold_clock_ms;     // wall clock fed to combo checks
  int unsigned tick_step_max;     // per-tick clock advance, scaled to thresholds

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;
  wire cfg_fire = cfg_valid && cfg_ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keypad_combo_hold_detector u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  keypad_event_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire || cfg_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: windows of random length, each with its own stall density
  // (mode 0 never stalls, mode 3 stalls with a probability of three in four). A hold-off
  // request from the stimulus side pins stall high for a long stretch.
  initial begin : receiver
    int unsigned mode;
    forever begin
      if (hold_off_req) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_OFF_LEN) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        repeat ($urandom_range(1, 60)) begin
          @(negedge clk);
          out_stall <= ($urandom_range(0, 3) < mode);
          if (hold_off_req) break;
        end
      end
    end
  end

  // One transfer on the item channel. Bursts of random length, with a random
  // gap (possibly none) ahead of each burst. Valid is only ever assigned once
  // per falling edge, so a held-high valid is never dropped and re-raised.
  task automatic offer_item(input kchd_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid, let every expected result come back, then a short settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_thresholds(input logic [15:0] rst_ms, input logic [15:0] pair_ms,
                                input logic [15:0] own_ms);
    int unsigned top_ms;
    write_reg(kchd_pkg::CFG_RESET_HOLD, rst_ms);
    write_reg(kchd_pkg::CFG_PAIRING_HOLD, pair_ms);
    write_reg(kchd_pkg::CFG_OWNER_HOLD, own_ms);
    @(negedge clk);
    cfg_valid <= 1'b0;
    // a few ticks should be enough to cross the longest hold
    top_ms = 32'(rst_ms);
    if (pair_ms > top_ms) top_ms = 32'(pair_ms);
    if (own_ms > top_ms) top_ms = 32'(own_ms);
    tick_step_max = top_ms / 2 + 1;
  endtask

  // Key events: unused fields random so every input bit toggles.
  function automatic kchd_pkg::in_item_t key_item(input logic [7:0] key,
                                                  input logic [1:0] st,
                                                  input logic setup);
    kchd_pkg::in_item_t it;
    it.action              = kchd_pkg::ACT_KEY;
    it.key_code            = key;
    it.key_state           = st;
    it.now_ms              = $urandom;
    it.setup_mode          = setup;
    it.reset_allowed       = 1'($urandom_range(0, 1));
    it.owner_reset_allowed = 1'($urandom_range(0, 1));
    it.pairing_allowed     = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic kchd_pkg::in_item_t combo_item(input logic [31:0] now,
                                                    input logic setup,
                                                    input logic rok, input logic ook,
                                                    input logic pok);
    kchd_pkg::in_item_t it;
    it.action              = kchd_pkg::ACT_COMBO;
    it.key_code            = 8'($urandom);
    it.key_state           = 2'($urandom);
    it.now_ms              = now;
    it.setup_mode          = setup;
    it.reset_allowed       = rok;
    it.owner_reset_allowed = ook;
    it.pairing_allowed     = pok;
    return it;
  endfunction

  // Plain key traffic: mostly digits and the two combo keys, sometimes any
  // byte, sometimes an odd key state, now and then in setup mode.
  function automatic kchd_pkg::in_item_t random_key_event();
    logic [7:0]  key;
    logic [1:0]  st;
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel <= 2)      key = kchd_pkg::KEY_0 + 8'($urandom_range(0, 9));
    else if (sel == 3) key = kchd_pkg::KEY_STAR;
    else if (sel == 4) key = kchd_pkg::KEY_HASH;
    else               key = 8'($urandom);
    st = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
    return key_item(key, st, $urandom_range(0, 7) == 0);
  endfunction

  function automatic kchd_pkg::in_item_t noise_item();
    kchd_pkg::in_item_t it;
    logic [63:0]        raw;
    raw = {$urandom, $urandom};
    it  = raw[$bits(kchd_pkg::in_item_t)-1:0];
    return it;
  endfunction

  // A well-formed star+hash hold: both keys down, a run of combo ticks with
  // an advancing clock, then both keys up. Permission flags pick one of the
  // three hold paths and occasionally flip mid-hold; stray keys, setup-mode
  // ticks, clock jumps and missing press/release are mixed in at low rates.
  task automatic hold_sequence();
    logic        rok, ook, pok;
    logic [7:0]  first_key, second_key;
    int unsigned path;
    path = $urandom_range(0, 2);
    rok  = (path == 0);
    ook  = (path == 1) || (path == 0 && $urandom_range(0, 1) != 0);
    pok  = (path == 2) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) != 0);
    first_key  = $urandom_range(0, 1) ? kchd_pkg::KEY_STAR : kchd_pkg::KEY_HASH;
    second_key = (first_key == kchd_pkg::KEY_STAR) ? kchd_pkg::KEY_HASH : kchd_pkg::KEY_STAR;
    offer_item(key_item(first_key, kchd_pkg::KEY_PRESSED, 1'b0));
    if ($urandom_range(0, 7) != 0)
      offer_item(key_item(second_key, kchd_pkg::KEY_PRESSED, 1'b0));
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 15) == 0) hold_clock_ms = $urandom;
      else hold_clock_ms += $urandom_range(0, tick_step_max);
      if ($urandom_range(0, 9) == 0) rok = ~rok;
      if ($urandom_range(0, 9) == 0) ook = ~ook;
      if ($urandom_range(0, 9) == 0) pok = ~pok;
      if ($urandom_range(0, 7) == 0) offer_item(random_key_event());
      offer_item(combo_item(hold_clock_ms, $urandom_range(0, 19) == 0, rok, ook, pok));
    end
    if ($urandom_range(0, 1)) begin
      first_key  = second_key;
      second_key = (first_key == kchd_pkg::KEY_STAR) ? kchd_pkg::KEY_HASH :
                                                       kchd_pkg::KEY_STAR;
    end
    if ($urandom_range(0, 7) != 0)
      offer_item(key_item(first_key, kchd_pkg::KEY_RELEASED, 1'b0));
    if ($urandom_range(0, 7) != 0)
      offer_item(key_item(second_key, kchd_pkg::KEY_RELEASED, 1'b0));
    if ($urandom_range(0, 1)) offer_item(combo_item(hold_clock_ms, 1'b0, rok, ook, pok));
  endtask

  initial begin : stimulus
    logic [31:0] t0;
    int          phase_end;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset thresholds (3000 / 3000 / 10000)
    t0 = 32'hFFFF_FA00;
    offer_item(key_item(8'hFF, kchd_pkg::KEY_PRESSED, 1'b1));   // setup key, top byte
    offer_item(key_item(8'h00, kchd_pkg::KEY_RELEASED, 1'b1));  // setup release: nothing
    offer_item(key_item(kchd_pkg::KEY_0, kchd_pkg::KEY_PRESSED, 1'b0));
    offer_item(key_item(kchd_pkg::KEY_9, kchd_pkg::KEY_PRESSED, 1'b0));
    offer_item(key_item(kchd_pkg::KEY_9, kchd_pkg::KEY_RELEASED, 1'b0));
    // just outside the digits
    offer_item(key_item(kchd_pkg::KEY_0 - 8'd1, kchd_pkg::KEY_PRESSED, 1'b0));
    offer_item(key_item(kchd_pkg::KEY_9 + 8'd1, kchd_pkg::KEY_PRESSED, 1'b0));
    offer_item(key_item(kchd_pkg::KEY_STAR, 2'd2, 1'b0));       // odd key states: ignored
    offer_item(key_item(kchd_pkg::KEY_HASH, 2'd3, 1'b0));
    offer_item(key_item(kchd_pkg::KEY_STAR, kchd_pkg::KEY_RELEASED, 1'b0));  // clear
    offer_item(key_item(kchd_pkg::KEY_HASH, kchd_pkg::KEY_RELEASED, 1'b0));  // submit
    // setup: held flag untouched
    offer_item(key_item(kchd_pkg::KEY_STAR, kchd_pkg::KEY_PRESSED, 1'b1));
    offer_item(key_item(kchd_pkg::KEY_STAR, kchd_pkg::KEY_PRESSED, 1'b0));
    offer_item(key_item(kchd_pkg::KEY_HASH, kchd_pkg::KEY_PRESSED, 1'b0));
    offer_item(combo_item(t0, 1'b1, 1'b1, 1'b1, 1'b1));   // setup-mode tick
    offer_item(combo_item(t0, 1'b0, 1'b1, 1'b0, 1'b0));   // reset hold starts
    offer_item(combo_item(t0 + 32'd2999, 1'b0, 1'b1, 1'b0, 1'b0));
    offer_item(combo_item(t0 + 32'd3000, 1'b0, 1'b1, 1'b0, 1'b0)); // fires across wrap
    offer_item(combo_item(t0 + 32'd4000, 1'b0, 1'b1, 1'b1, 1'b1)); // muted, keys held
    // muted release
    offer_item(key_item(kchd_pkg::KEY_STAR, kchd_pkg::KEY_RELEASED, 1'b0));
    offer_item(key_item(kchd_pkg::KEY_HASH, kchd_pkg::KEY_RELEASED, 1'b0));
    offer_item(combo_item(32'd0, 1'b0, 1'b0, 1'b0, 1'b0)); // both up: unmute
    offer_item(key_item(kchd_pkg::KEY_HASH, kchd_pkg::KEY_PRESSED, 1'b0));
    offer_item(key_item(kchd_pkg::KEY_STAR, kchd_pkg::KEY_PRESSED, 1'b0));
    offer_item(combo_item(32'd5000, 1'b0, 1'b0, 1'b0, 1'b1));  // pairing starts
    offer_item(combo_item(32'd6000, 1'b0, 1'b0, 1'b1, 1'b1));  // owner takes over
    offer_item(combo_item(32'd16000, 1'b0, 1'b0, 1'b1, 1'b1)); // owner fires

    // Random phases, one threshold setting each, extremes first
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_thresholds(16'd0, 16'd0, 16'd0);           // fire on first tick
        1: set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_thresholds(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                          16'($urandom_range(0, 200)));
        3: begin
          write_reg(CFG_SPARE_IDX, 16'($urandom));        // must not land anywhere
          set_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
        end
        default: set_thresholds(kchd_pkg::RESET_HOLD_DEFAULT,
                                kchd_pkg::PAIRING_HOLD_DEFAULT,
                                kchd_pkg::OWNER_HOLD_DEFAULT);
      endcase
      hold_clock_ms = $urandom;
      // Back-pressure: hold the output off while items keep coming, so the
      // block fills up and stalls its input.
      if (phase == 2) hold_off_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) hold_sequence();
        else if ($urandom_range(0, 1)) offer_item(noise_item());
        else offer_item(random_key_event());
      end
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
